// ===== rtl/core/co2_sensor_read_controller_top_macros.svh =====
// Assertion macros shared by the CO2 sensor read controller modules.
`ifndef CO2_SENSOR_READ_CONTROLLER_TOP_MACROS_SVH
`define CO2_SENSOR_READ_CONTROLLER_TOP_MACROS_SVH

`define CO2RC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`define CO2RC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CO2RC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/co2rc_pkg.sv =====
// Package with types, codes and constants of the CO2 sensor read controller.
package co2rc_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int FRAME_IDX_W = 4;
  localparam logic [FRAME_IDX_W-1:0] FRAME_LAST_IDX = FRAME_IDX_W'(FRAME_BYTES - 1);

  localparam int TICK_COUNT_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int TIMEOUT_W = 16;
  localparam int WARM_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_READ_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_UP_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_OPCODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ADDR = 3'd5;

  localparam logic [TIMEOUT_W-1:0] RST_READ_TIMEOUT = 16'd1000;
  localparam logic [WARM_W-1:0] RST_WARM_UP_TICKS = 24'd180000;
  localparam logic [7:0] RST_WARM_TEMP = 8'd0;
  localparam logic [7:0] RST_START_BYTE = 8'd255;
  localparam logic [7:0] RST_READ_OPCODE = 8'd134;
  localparam logic [7:0] RST_SENSOR_ADDR = 8'd1;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE = 2'd2;
  localparam logic [1:0] CMD_ERR_RESET = 2'd3;

  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_READING = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_NO_ANSWER = 3'd1;
  localparam logic [2:0] ERR_CHECK = 3'd2;
  localparam logic [2:0] ERR_MISSING = 3'd3;
  localparam logic [2:0] ERR_NOT_WARM = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last_in_run;
    logic [15:0] co2_level;
    logic [7:0]  temperature;
    logic [2:0]  error_code;
    logic        busy_res;
  } res_t;

  typedef struct packed {
    logic       is_frame;
    logic [7:0] start_byte;
    logic [7:0] sensor_address;
    logic [7:0] read_opcode;
    logic [7:0] check_byte;
    res_t       single;
  } job_t;

endpackage

// ===== rtl/core/co2rc_front.sv =====
// Front end: configuration registers, protocol state and job classification.
module co2rc_front #(
  parameter int TICK_COUNT_WIDTH = co2rc_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [co2rc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [co2rc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  input  logic [1:0]                      command,
  input  logic [7:0]                      rx_byte,
  output logic                            push,
  output co2rc_pkg::job_t                 push_job
);

  `include "co2_sensor_read_controller_top_macros.svh"

  localparam int CmpW = (TICK_COUNT_WIDTH > co2rc_pkg::WARM_W) ?
                        TICK_COUNT_WIDTH : co2rc_pkg::WARM_W;

  typedef enum logic [4:0] {
    PH_INIT   = 5'b00001,
    PH_IDLE   = 5'b00010,
    PH_GATHER = 5'b00100,
    PH_READY  = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_t;

  logic [co2rc_pkg::TIMEOUT_W-1:0] timeout_cfg_r;
  logic [co2rc_pkg::WARM_W-1:0]    warm_ticks_cfg_r;
  logic [7:0]                      warm_temp_cfg_r;
  logic [7:0]                      start_cfg_r;
  logic [7:0]                      opcode_cfg_r;
  logic [7:0]                      addr_cfg_r;

  phase_t                            phase_r, phase_nxt;
  logic                              pending_r, pending_nxt;
  logic                              warm_needed_r, warm_needed_nxt;
  logic [TICK_COUNT_WIDTH-1:0]       warm_cnt_r, warm_cnt_nxt;
  logic [co2rc_pkg::TIMEOUT_W-1:0]   tmo_cnt_r, tmo_cnt_nxt;
  logic [co2rc_pkg::FRAME_IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0]                        sum_r, sum_nxt;
  logic [7:0]                        reply_r [3];

  logic                              reply_we;
  logic [1:0]                        reply_wr_idx;
  logic [co2rc_pkg::TIMEOUT_W-1:0]   tmo_inc;
  logic [CmpW-1:0]                   warm_cnt_ext;
  logic [CmpW-1:0]                   warm_ticks_ext;
  logic                              warm_clear;
  logic [7:0]                        hdr_sum;

  assign warm_cnt_ext   = CmpW'(warm_cnt_r);
  assign warm_ticks_ext = CmpW'(warm_ticks_cfg_r);
  assign warm_clear     = (reply_r[2] > warm_temp_cfg_r) || (warm_cnt_ext > warm_ticks_ext);
  assign tmo_inc        = (tmo_cnt_r != '1) ? tmo_cnt_r + 1'b1 : tmo_cnt_r;
  assign hdr_sum        = start_cfg_r + addr_cfg_r + opcode_cfg_r;
  assign reply_wr_idx   = 2'(byte_idx_r - co2rc_pkg::FRAME_IDX_W'(2));

  always_comb begin
    phase_nxt       = phase_r;
    pending_nxt     = pending_r;
    warm_needed_nxt = warm_needed_r;
    warm_cnt_nxt    = warm_cnt_r;
    tmo_cnt_nxt     = tmo_cnt_r;
    byte_idx_nxt    = byte_idx_r;
    sum_nxt         = sum_r;
    reply_we        = 1'b0;
    push            = 1'b0;
    push_job        = '0;
    if (accept) begin
      unique case (command)
        co2rc_pkg::CMD_TICK: begin
          if (warm_cnt_r != '1) begin
            warm_cnt_nxt = warm_cnt_r + 1'b1;
          end
          unique case (phase_r)
            PH_IDLE: begin
              if (pending_r) begin
                pending_nxt             = 1'b0;
                push                    = 1'b1;
                push_job.is_frame       = 1'b1;
                push_job.start_byte     = start_cfg_r;
                push_job.sensor_address = addr_cfg_r;
                push_job.read_opcode    = opcode_cfg_r;
                push_job.check_byte     = ~hdr_sum;
                tmo_cnt_nxt             = '0;
                byte_idx_nxt            = '0;
                sum_nxt                 = '0;
                phase_nxt               = PH_GATHER;
              end
            end
            PH_GATHER: begin
              tmo_cnt_nxt = tmo_inc;
              if (tmo_inc >= timeout_cfg_r) begin
                push                      = 1'b1;
                push_job.single.kind      = co2rc_pkg::KIND_ERROR;
                push_job.single.error_code = (byte_idx_r == '0) ?
                                             co2rc_pkg::ERR_NO_ANSWER : co2rc_pkg::ERR_MISSING;
                phase_nxt                 = PH_ERROR;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        co2rc_pkg::CMD_READ: begin
          pending_nxt             = 1'b1;
          push                    = 1'b1;
          push_job.single.kind    = co2rc_pkg::KIND_STATUS;
          push_job.single.busy_res = !((phase_r == PH_IDLE) || (phase_r == PH_READY));
        end
        co2rc_pkg::CMD_RX_BYTE: begin
          if (phase_r == PH_GATHER) begin
            if (byte_idx_r < co2rc_pkg::FRAME_LAST_IDX) begin
              sum_nxt      = sum_r + rx_byte;
              reply_we     = (byte_idx_r >= co2rc_pkg::FRAME_IDX_W'(2)) &&
                             (byte_idx_r <= co2rc_pkg::FRAME_IDX_W'(4));
              byte_idx_nxt = byte_idx_r + 1'b1;
            end else begin
              byte_idx_nxt = '0;
              push         = 1'b1;
              if (~sum_r != rx_byte) begin
                push_job.single.kind       = co2rc_pkg::KIND_ERROR;
                push_job.single.error_code = co2rc_pkg::ERR_CHECK;
                phase_nxt                  = PH_ERROR;
              end else begin
                warm_needed_nxt = warm_needed_r && !warm_clear;
                if (warm_needed_nxt) begin
                  push_job.single.kind       = co2rc_pkg::KIND_ERROR;
                  push_job.single.error_code = co2rc_pkg::ERR_NOT_WARM;
                  phase_nxt                  = PH_ERROR;
                end else begin
                  push_job.single.kind        = co2rc_pkg::KIND_READING;
                  push_job.single.co2_level   = {reply_r[0], reply_r[1]};
                  push_job.single.temperature = reply_r[2];
                  phase_nxt                   = PH_READY;
                end
              end
            end
          end
        end
        co2rc_pkg::CMD_ERR_RESET: begin
          phase_nxt = PH_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_cfg_r    <= co2rc_pkg::RST_READ_TIMEOUT;
      warm_ticks_cfg_r <= co2rc_pkg::RST_WARM_UP_TICKS;
      warm_temp_cfg_r  <= co2rc_pkg::RST_WARM_TEMP;
      start_cfg_r      <= co2rc_pkg::RST_START_BYTE;
      opcode_cfg_r     <= co2rc_pkg::RST_READ_OPCODE;
      addr_cfg_r       <= co2rc_pkg::RST_SENSOR_ADDR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        co2rc_pkg::REG_READ_TIMEOUT:  timeout_cfg_r    <= cfg_data[co2rc_pkg::TIMEOUT_W-1:0];
        co2rc_pkg::REG_WARM_UP_TICKS: warm_ticks_cfg_r <= cfg_data[co2rc_pkg::WARM_W-1:0];
        co2rc_pkg::REG_WARM_TEMP:     warm_temp_cfg_r  <= cfg_data[7:0];
        co2rc_pkg::REG_START_BYTE:    start_cfg_r      <= cfg_data[7:0];
        co2rc_pkg::REG_READ_OPCODE:   opcode_cfg_r     <= cfg_data[7:0];
        co2rc_pkg::REG_SENSOR_ADDR:   addr_cfg_r       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_INIT;
      pending_r     <= 1'b0;
      warm_needed_r <= 1'b1;
      warm_cnt_r    <= '0;
      tmo_cnt_r     <= '0;
      byte_idx_r    <= '0;
      sum_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      pending_r     <= pending_nxt;
      warm_needed_r <= warm_needed_nxt;
      warm_cnt_r    <= warm_cnt_nxt;
      tmo_cnt_r     <= tmo_cnt_nxt;
      byte_idx_r    <= byte_idx_nxt;
      sum_r         <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_we) begin
      reply_r[reply_wr_idx] <= rx_byte;
    end
  end

  `CO2RC_ASSERT_ALWAYS(a_byte_idx_bound, byte_idx_r <= co2rc_pkg::FRAME_LAST_IDX, "reply byte index out of frame")
  `CO2RC_ASSERT_NEXT(a_warm_sticky, !warm_needed_r, !warm_needed_r, "warm-up flag set again after clearing")

endmodule

// ===== rtl/core/co2rc_queue.sv =====
// Short job queue between the front end and the result sequencer.
module co2rc_queue #(
  parameter int QUEUE_DEPTH = co2rc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  co2rc_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output co2rc_pkg::job_t head,
  output logic            empty
);

  `include "co2_sensor_read_controller_top_macros.svh"

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  co2rc_pkg::job_t slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CntFull);
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  `CO2RC_ASSERT_SAME(a_no_lost_push, push, !full, "job pushed into a full queue")

endmodule

// ===== rtl/core/co2rc_back.sv =====
// Back end: expands queued jobs into result items through an output register.
module co2rc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  co2rc_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output co2rc_pkg::res_t out_res
);

  `include "co2_sensor_read_controller_top_macros.svh"

  logic [co2rc_pkg::FRAME_IDX_W-1:0] idx_r, idx_nxt;
  logic                              valid_r, valid_nxt;
  co2rc_pkg::res_t                   res_r;
  co2rc_pkg::res_t                   res_nxt;
  logic                              load;

  assign load      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    res_nxt = '0;
    if (head.is_frame) begin
      res_nxt.kind        = co2rc_pkg::KIND_TX;
      res_nxt.last_in_run = (idx_r == co2rc_pkg::FRAME_LAST_IDX);
      priority if (idx_r == co2rc_pkg::FRAME_IDX_W'(0)) begin
        res_nxt.tx_byte = head.start_byte;
      end else if (idx_r == co2rc_pkg::FRAME_IDX_W'(1)) begin
        res_nxt.tx_byte = head.sensor_address;
      end else if (idx_r == co2rc_pkg::FRAME_IDX_W'(2)) begin
        res_nxt.tx_byte = head.read_opcode;
      end else if (idx_r == co2rc_pkg::FRAME_LAST_IDX) begin
        res_nxt.tx_byte = head.check_byte;
      end else begin
        res_nxt.tx_byte = '0;
      end
    end else begin
      res_nxt             = head.single;
      res_nxt.last_in_run = 1'b1;
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        if (res_nxt.last_in_run) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      res_r <= res_nxt;
    end
  end

  `CO2RC_ASSERT_SAME(a_idx_in_frame, idx_r != '0, !empty && head.is_frame, "frame position set without a frame job")

endmodule

// ===== rtl/core/co2_sensor_read_controller_top.sv =====
// Top level of the CO2 sensor read controller.
//
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid/in_ready    command, received byte
//   out_      output     out_valid/out_ready  transmit bytes, reports, status
//   cfg_      input      cfg_valid/cfg_ready  register index and write data
//
// The front end takes one input request per cycle while the job queue has room.
// A tick that sends the frame yields nine transmit results, one per cycle while out_ready is high; others at most one.
// An accepted request's job is registered in the job queue, and its first result then in the output register.
// Results leave through a registered output stage, so output stalls fill the queue and, once it is full, stall input.
// Reset is synchronous; there is no clearing pass.
// Configuration writes are taken in any cycle.
module co2_sensor_read_controller_top #(
  parameter int TICK_COUNT_WIDTH = co2rc_pkg::TICK_COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH      = co2rc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_command,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_tx_byte,
  output logic                             out_last_in_run,
  output logic [15:0]                      out_co2_level,
  output logic [7:0]                       out_temperature,
  output logic [2:0]                       out_error_code,
  output logic                             out_busy_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [co2rc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [co2rc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            push;
  co2rc_pkg::job_t push_job;
  co2rc_pkg::job_t head;
  co2rc_pkg::res_t res;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  co2rc_front #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (in_valid && in_ready),
    .command  (in_command),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_job (push_job)
  );

  co2rc_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (head),
    .empty   (q_empty)
  );

  co2rc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_kind        = res.kind;
  assign out_tx_byte     = res.tx_byte;
  assign out_last_in_run = res.last_in_run;
  assign out_co2_level   = res.co2_level;
  assign out_temperature = res.temperature;
  assign out_error_code  = res.error_code;
  assign out_busy_res    = res.busy_res;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the CO2 sensor read controller with a cycle-free behavioral predictor.
module tb_top;
  import co2rc_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_GATHER, ST_READY, ST_ERROR} ctrl_phase_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_command;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_kind;
  logic [7:0]            out_tx_byte;
  logic                  out_last_in_run;
  logic [15:0]           out_co2_level;
  logic [7:0]            out_temperature;
  logic [2:0]            out_error_code;
  logic                  out_busy_res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  co2_sensor_read_controller_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_last_in_run (out_last_in_run),
    .out_co2_level   (out_co2_level),
    .out_temperature (out_temperature),
    .out_error_code  (out_error_code),
    .out_busy_res    (out_busy_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  logic [15:0] timeout_cfg;
  logic [23:0] warm_ticks_cfg;
  logic [7:0]  warm_temp_cfg;
  logic [7:0]  start_cfg;
  logic [7:0]  opcode_cfg;
  logic [7:0]  addr_cfg;

  ctrl_phase_e ph;
  bit          req_pending;
  bit          warm_needed;
  logic [23:0] warm_count;
  logic [15:0] wait_ticks;
  logic [3:0]  byte_idx;
  logic [7:0]  rx_total;
  logic [7:0]  reply_mem [3];

  res_t expected_results[$];
  int   error_count = 0;
  int   results_seen = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   hold_cycles = 0;
  bit   send_gaps = 1'b1;
  bit   recv_stalls = 1'b1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic res_t make_result(input logic [1:0] kind, input logic [7:0] tx,
                                       input logic [15:0] co2, input logic [7:0] temp,
                                       input logic [2:0] err, input logic busy);
    res_t r;
    r.kind        = kind;
    r.tx_byte     = tx;
    r.last_in_run = 1'b0;
    r.co2_level   = co2;
    r.temperature = temp;
    r.error_code  = err;
    r.busy_res    = busy;
    return r;
  endfunction

  task automatic predict_item(input logic [1:0] cmd, input logic [7:0] rx);
    res_t        run[$];
    res_t        r;
    logic [7:0]  frame [FRAME_BYTES];
    logic [7:0]  total;
    logic [15:0] co2;
    case (cmd)
      CMD_TICK: begin
        if (warm_count != '1) warm_count = warm_count + 24'd1;
        case (ph)
          ST_IDLE: begin
            if (req_pending) begin
              req_pending = 1'b0;
              foreach (frame[i]) frame[i] = 8'h00;
              frame[0] = start_cfg;
              frame[1] = addr_cfg;
              frame[2] = opcode_cfg;
              total = 8'h00;
              for (int i = 0; i < FRAME_BYTES - 1; i++) total = total + frame[i];
              frame[FRAME_BYTES-1] = ~total;
              foreach (frame[i]) begin
                run.push_back(make_result(KIND_TX, frame[i], 16'h0000, 8'h00, ERR_NONE, 1'b0));
              end
              wait_ticks = 16'h0000;
              byte_idx   = 4'd0;
              rx_total   = 8'h00;
              ph         = ST_GATHER;
            end
          end
          ST_GATHER: begin
            if (wait_ticks != 16'hFFFF) wait_ticks = wait_ticks + 16'd1;
            if (wait_ticks >= timeout_cfg) begin
              run.push_back(make_result(KIND_ERROR, 8'h00, 16'h0000, 8'h00,
                                        (byte_idx == 4'd0) ? ERR_NO_ANSWER : ERR_MISSING, 1'b0));
              ph = ST_ERROR;
            end
          end
          default: ph = ST_IDLE;
        endcase
      end
      CMD_READ: begin
        req_pending = 1'b1;
        run.push_back(make_result(KIND_STATUS, 8'h00, 16'h0000, 8'h00, ERR_NONE,
                                  !(ph == ST_IDLE || ph == ST_READY)));
      end
      CMD_RX_BYTE: begin
        if (ph == ST_GATHER) begin
          if (byte_idx < FRAME_LAST_IDX) begin
            rx_total = rx_total + rx;
            if (byte_idx >= 4'd2 && byte_idx <= 4'd4) reply_mem[byte_idx - 4'd2] = rx;
            byte_idx = byte_idx + 4'd1;
          end else begin
            byte_idx = 4'd0;
            if (~rx_total != rx) begin
              run.push_back(make_result(KIND_ERROR, 8'h00, 16'h0000, 8'h00, ERR_CHECK, 1'b0));
              ph = ST_ERROR;
            end else begin
              co2 = {reply_mem[0], reply_mem[1]};
              if (reply_mem[2] > warm_temp_cfg || warm_count > warm_ticks_cfg) begin
                warm_needed = 1'b0;
              end
              if (warm_needed) begin
                run.push_back(make_result(KIND_ERROR, 8'h00, 16'h0000, 8'h00, ERR_NOT_WARM,
                                          1'b0));
                ph = ST_ERROR;
              end else begin
                run.push_back(make_result(KIND_READING, 8'h00, co2, reply_mem[2], ERR_NONE,
                                          1'b0));
                ph = ST_READY;
              end
            end
          end
        end
      end
      default: ph = ST_INIT;
    endcase
    if (run.size() > 0) begin
      r = run.pop_back();
      r.last_in_run = 1'b1;
      run.push_back(r);
    end
    foreach (run[i]) expected_results.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", 16'(out_kind), 16'(want.kind));
        compare_field("tx_byte", 16'(out_tx_byte), 16'(want.tx_byte));
        compare_field("last_in_run", 16'(out_last_in_run), 16'(want.last_in_run));
        compare_field("co2_level", out_co2_level, want.co2_level);
        compare_field("temperature", 16'(out_temperature), 16'(want.temperature));
        compare_field("error_code", 16'(out_error_code), 16'(want.error_code));
        compare_field("busy_res", 16'(out_busy_res), 16'(want.busy_res));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = recv_stalls ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx);
    int gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (!(cmd == CMD_RX_BYTE && ph != ST_GATHER)) items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= rx;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_item(cmd, rx);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic configure(input logic [15:0] timeout_v, input logic [23:0] warm_ticks_v,
                           input logic [7:0] warm_temp_v, input logic [7:0] start_v,
                           input logic [7:0] opcode_v, input logic [7:0] addr_v);
    wait_idle();
    write_reg(REG_READ_TIMEOUT, CFG_DATA_W'(timeout_v));
    write_reg(REG_WARM_UP_TICKS, warm_ticks_v);
    write_reg(REG_WARM_TEMP, CFG_DATA_W'(warm_temp_v));
    write_reg(REG_START_BYTE, CFG_DATA_W'(start_v));
    write_reg(REG_READ_OPCODE, CFG_DATA_W'(opcode_v));
    write_reg(REG_SENSOR_ADDR, CFG_DATA_W'(addr_v));
    cfg_valid <= 1'b0;
    timeout_cfg    = timeout_v;
    warm_ticks_cfg = warm_ticks_v;
    warm_temp_cfg  = warm_temp_v;
    start_cfg      = start_v;
    opcode_cfg     = opcode_v;
    addr_cfg       = addr_v;
  endtask

  task automatic configure_random();
    logic [15:0] t;
    logic [23:0] w;
    logic [7:0]  temp;
    int          sel;
    t = ($urandom_range(0, 3) == 0) ? 16'd1 : 16'($urandom_range(2, 40));
    sel = $urandom_range(0, 2);
    w = (sel == 0) ? 24'h000000 : (sel == 1) ? 24'hFFFFFF : 24'($urandom);
    sel = $urandom_range(0, 2);
    temp = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    configure(t, w, temp, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // The reply gets an occasional tick between bytes, never enough to run out the timer.
  task automatic send_reply(input int n_bytes, input bit corrupt, input logic [15:0] co2,
                            input logic [7:0] temp);
    logic [7:0] reply [FRAME_BYTES];
    logic [7:0] total;
    total = 8'h00;
    foreach (reply[i]) reply[i] = 8'($urandom);
    reply[2] = co2[15:8];
    reply[3] = co2[7:0];
    reply[4] = temp;
    for (int i = 0; i < FRAME_BYTES - 1; i++) total = total + reply[i];
    reply[FRAME_BYTES-1] = corrupt ? (~total ^ (8'h01 << $urandom_range(0, 7))) : ~total;
    for (int i = 0; i < n_bytes; i++) begin
      if (ph == ST_GATHER && int'(wait_ticks) + 1 < int'(timeout_cfg) &&
          $urandom_range(0, 5) == 0) begin
        send_item(CMD_TICK, 8'($urandom));
      end
      send_item(CMD_RX_BYTE, reply[i]);
    end
  endtask

  task automatic finish_timeout();
    while (ph == ST_GATHER) send_item(CMD_TICK, 8'($urandom));
  endtask

  task automatic start_read();
    if (ph == ST_GATHER) send_item(CMD_ERR_RESET, 8'($urandom));
    while (ph != ST_IDLE) send_item(CMD_TICK, 8'($urandom));
    if (!req_pending || $urandom_range(0, 3) == 0) send_item(CMD_READ, 8'($urandom));
    send_item(CMD_TICK, 8'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_item(CMD_READ, 8'h00);
    send_item(CMD_RX_BYTE, 8'hFF);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_READ, 8'hFF);
    send_reply(FRAME_BYTES, 1'b0, 16'h0000, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_ERR_RESET, 8'hFF);
    send_item(CMD_TICK, 8'h00);
  endtask

  task automatic test_zero_timeout();
    configure(16'd0, 24'hFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
  endtask

  task automatic test_missing_data();
    configure(16'd3, RST_WARM_UP_TICKS, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_reply(1, 1'b0, 16'h0000, 8'h00);
    finish_timeout();
  endtask

  task automatic test_warm_by_count();
    configure(16'hFFFF, 24'h000000, 8'hFF, RST_START_BYTE, RST_READ_OPCODE, RST_SENSOR_ADDR);
    start_read();
    send_reply(FRAME_BYTES, 1'b0, 16'hFFFF, 8'hFF);
    send_item(CMD_READ, 8'h00);
  endtask

  // The receiver holds off while frames keep coming, so the request path must stall.
  task automatic test_backpressure();
    configure(16'd20, 24'h000000, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom));
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    hold_cycles = 100;
    repeat (5) start_read();
    wait_idle();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    int first;
    int seq;
    int pick;
    first = items_sent;
    seq = 0;
    while (items_sent - first < count) begin
      if (seq % 4 == 0) configure_random();
      seq++;
      send_gaps   = ($urandom_range(0, 4) != 0);
      recv_stalls = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom));
      end else begin
        start_read();
        if (pick < 6) begin
          send_reply(FRAME_BYTES, 1'b0, 16'($urandom), 8'($urandom));
        end else if (pick < 8) begin
          send_reply(FRAME_BYTES, 1'b1, 16'($urandom), 8'($urandom));
        end else if (pick == 8) begin
          send_reply($urandom_range(1, FRAME_BYTES - 1), 1'b0, 16'($urandom), 8'($urandom));
          finish_timeout();
        end else begin
          finish_timeout();
        end
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_TICK;
    in_rx_byte <= 8'h00;
    out_ready  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_READ_TIMEOUT;
    cfg_data   <= '0;
    timeout_cfg    = RST_READ_TIMEOUT;
    warm_ticks_cfg = RST_WARM_UP_TICKS;
    warm_temp_cfg  = RST_WARM_TEMP;
    start_cfg      = RST_START_BYTE;
    opcode_cfg     = RST_READ_OPCODE;
    addr_cfg       = RST_SENSOR_ADDR;
    ph          = ST_INIT;
    req_pending = 1'b0;
    warm_needed = 1'b1;
    warm_count  = 24'd0;
    wait_ticks  = 16'd0;
    byte_idx    = 4'd0;
    rx_total    = 8'h00;
    foreach (reply_mem[i]) reply_mem[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_timeout();
    test_missing_data();
    test_warm_by_count();
    test_backpressure();
    test_random_traffic(90);
    wait_idle();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
